[hw/rtl/diff_pressure_frame_check_average_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the differential pressure frame checker
// Shared helpers that clock every property on the rising edge of clock and
// disable it while reset is high.
// ----------------------------------------------------------------------------
`ifndef DIFF_PRESSURE_FRAME_CHECK_AVERAGE_UNIT_MACROS_SVH
`define DIFF_PRESSURE_FRAME_CHECK_AVERAGE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPFCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPFCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dpfca_pkg.sv]
// ----------------------------------------------------------------------------
// Differential pressure frame checker package
// Channel payload types, function and result codes, register indexes, the
// controller/datapath interface types and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package dpfca_pkg;

   // Field widths fixed by the interface.
   localparam int VALUE_W     = 24;
   localparam int SUM_W       = 24;
   localparam int COUNT_W     = 8;
   localparam int AGE_W       = 16;
   localparam int CFG_W       = 16;
   localparam int FRAME_STORE = 5;

   // Request function codes.
   localparam logic [2:0] FUNC_BYTE    = 3'd0;
   localparam logic [2:0] FUNC_TICK    = 3'd1;
   localparam logic [2:0] FUNC_FAIL    = 3'd2;
   localparam logic [2:0] FUNC_RD_PRES = 3'd3;
   localparam logic [2:0] FUNC_RD_TEMP = 3'd4;

   // Response kind codes.
   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_PRES  = 2'd1;
   localparam logic [1:0] KIND_TEMP  = 2'd2;
   localparam logic [1:0] KIND_FAIL  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCALE     = 2'd0;
   localparam logic [1:0] CSR_STALE     = 2'd1;
   localparam logic [1:0] CSR_RECONNECT = 2'd2;

   // Configuration reset values.
   localparam logic [CFG_W-1:0] SCALE_RESET     = 16'd60;
   localparam logic [CFG_W-1:0] STALE_RESET     = 16'd100;
   localparam logic [CFG_W-1:0] RECONNECT_RESET = 16'd200;

   // Temperature raw counts per degree.
   localparam logic [CFG_W-1:0] TEMP_DIVISOR = 16'd200;

   // CRC-8 definition of the sensor words.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hff;

   // Byte positions inside a frame.
   localparam logic [2:0] POS_FIRST   = 3'd0;
   localparam logic [2:0] POS_CRC_P   = 3'd2;
   localparam logic [2:0] POS_TEMP_HI = 3'd3;
   localparam logic [2:0] POS_LAST    = 3'd5;
   localparam logic [2:0] POS_IDLE    = 3'd6;

   // Saturation bounds of the averaged value.
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 24'sh7fffff;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 24'sh800000;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] byte_value;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0]                 kind;
      logic                       frame_good;
      logic                       fresh;
      logic signed [VALUE_W-1:0]  value;
      logic                       reconnect;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic load_div;
      logic div_step;
      logic finish;
      logic load_out;
   } ctrl_cmd_type;

   // Status from the datapath to the controller, about the offered request.
   typedef struct packed {
      logic has_result;
      logic needs_div;
   } ctrl_status_type;

   // One byte of the MSB-first CRC-8 update.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[hw/rtl/dpfca_ctrl.sv]
// ----------------------------------------------------------------------------
// Differential pressure frame checker controller
// Sequences one request at a time: accept, optional multiply and bit-serial
// divide for an average, saturation, and the load of the response register.
// ----------------------------------------------------------------------------
module dpfca_ctrl import dpfca_pkg::*; #(
   parameter int DIV_STEPS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire;
   logic             out_free;

   // A request is taken only in idle; the response register may still be full.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.accept = 1'b1;
               if (status.needs_div) begin
                  state_in = ST_MUL;
               end else if (status.has_result) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            cmd.load_div = 1'b1;
            cnt_in       = CNT_LAST;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/dpfca_datapath.sv]
// ----------------------------------------------------------------------------
// Differential pressure frame checker datapath
// Frame assembly with a running CRC-8, sums and counts, sample age,
// configuration registers, a restoring divider and the response register.
// ----------------------------------------------------------------------------
module dpfca_datapath import dpfca_pkg::*; #(
   parameter int MAX_COUNT = 255,
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  ctrl_cmd_type     cmd,
   output ctrl_status_type  status,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data,
   output rsp_type          rsp_data
);

   localparam int NUM_W = SUM_W + FRAC_BITS;
   localparam int DEN_W = COUNT_W + CFG_W;
   localparam logic [NUM_W-1:0] Q_POS_LIM = NUM_W'(24'h7fffff);
   localparam logic [NUM_W-1:0] Q_NEG_LIM = NUM_W'(24'h800000);
   localparam logic [COUNT_W-1:0] COUNT_LIM = COUNT_W'(MAX_COUNT);

   // Frame and accumulation state.
   logic [2:0]                pos_ff, pos_in;
   logic [7:0]                bytes_ff [FRAME_STORE];
   logic [7:0]                bytes_in [FRAME_STORE];
   logic [7:0]                crc_ff, crc_in;
   logic                      crc_ok_ff, crc_ok_in;
   logic signed [SUM_W-1:0]   psum_ff, psum_in, tsum_ff, tsum_in;
   logic [COUNT_W-1:0]        pcnt_ff, pcnt_in, tcnt_ff, tcnt_in;
   logic signed [VALUE_W-1:0] plast_ff, plast_in, tlast_ff, tlast_in;
   logic [AGE_W-1:0]          age_ff, age_in;

   // Configuration registers.
   logic [CFG_W-1:0]          scale_ff, scale_in, stale_ff, stale_in, recon_ff, recon_in;

   // Divider state.
   logic                      sel_temp_ff, sel_temp_in;
   logic                      neg_ff, neg_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [NUM_W-1:0]          num_ff, num_in, quo_ff, quo_in;

   // Result staging and response register.
   rsp_type                   res_ff, res_in, rsp_ff, rsp_in;

   // Combinational helpers.
   logic [2:0]                pos_eff;
   logic                      fresh_now;
   logic                      frame_good;
   logic [7:0]                crc_base;
   logic signed [SUM_W-1:0]   p_word, t_word, sum_sel;
   logic [COUNT_W-1:0]        cnt_sel;
   logic [CFG_W-1:0]          div_sel;
   logic [SUM_W-1:0]          mag;
   logic [DEN_W:0]            rem_sh;
   logic                      ge;
   logic signed [VALUE_W-1:0] sat;

   assign pos_eff    = req_data.frame_start ? POS_FIRST : pos_ff;
   assign fresh_now  = (age_ff <= stale_ff);
   assign frame_good = crc_ok_ff && (crc_ff == req_data.byte_value);
   assign crc_base   = (pos_eff == POS_FIRST || pos_eff == POS_TEMP_HI) ? CRC_INIT : crc_ff;
   assign p_word     = SUM_W'($signed({bytes_ff[0], bytes_ff[1]}));
   assign t_word     = SUM_W'($signed({bytes_ff[3], bytes_ff[4]}));

   // Decode of the offered request for the controller.
   always_comb begin
      status.has_result = (req_data.func == FUNC_BYTE && pos_eff == POS_LAST)
                          || (req_data.func inside {FUNC_FAIL, FUNC_RD_PRES, FUNC_RD_TEMP});
      status.needs_div  = fresh_now
                          && ((req_data.func == FUNC_RD_PRES && pcnt_ff != '0)
                              || (req_data.func == FUNC_RD_TEMP && tcnt_ff != '0));
   end

   // Divider operands, one restoring step, and saturation of the quotient.
   always_comb begin
      sum_sel = sel_temp_ff ? tsum_ff : psum_ff;
      cnt_sel = sel_temp_ff ? tcnt_ff : pcnt_ff;
      if (sel_temp_ff) begin
         div_sel = TEMP_DIVISOR;
      end else begin
         div_sel = (scale_ff == '0) ? CFG_W'(1) : scale_ff;
      end
      mag    = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = (rem_sh >= {1'b0, den_ff});
      if (neg_ff) begin
         sat = (quo_ff > Q_NEG_LIM) ? VAL_MIN : VALUE_W'(~quo_ff[VALUE_W-1:0] + VALUE_W'(1));
      end else begin
         sat = (quo_ff > Q_POS_LIM) ? VAL_MAX : VALUE_W'(quo_ff[VALUE_W-1:0]);
      end
   end

   // Next values of all state.
   always_comb begin
      pos_in      = pos_ff;
      bytes_in    = bytes_ff;
      crc_in      = crc_ff;
      crc_ok_in   = crc_ok_ff;
      psum_in     = psum_ff;
      tsum_in     = tsum_ff;
      pcnt_in     = pcnt_ff;
      tcnt_in     = tcnt_ff;
      plast_in    = plast_ff;
      tlast_in    = tlast_ff;
      age_in      = age_ff;
      scale_in    = scale_ff;
      stale_in    = stale_ff;
      recon_in    = recon_ff;
      sel_temp_in = sel_temp_ff;
      neg_in      = neg_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;

      // Configuration writes; an index past the list is dropped.
      if (csr_write) begin
         case (csr_index)
            CSR_SCALE:     scale_in = csr_data;
            CSR_STALE:     stale_in = csr_data;
            CSR_RECONNECT: recon_in = csr_data;
            default:       ;
         endcase
      end

      // Effects of an accepted request.
      if (cmd.accept) begin
         res_in = '0;
         case (req_data.func)
            FUNC_BYTE: begin
               if (pos_eff < POS_LAST) begin
                  bytes_in[pos_eff] = req_data.byte_value;
                  pos_in = 3'(pos_eff + 3'd1);
                  if (pos_eff == POS_CRC_P) begin
                     crc_ok_in = (crc_ff == req_data.byte_value);
                  end else begin
                     crc_in = crc8_byte(crc_base, req_data.byte_value);
                  end
               end else if (pos_eff == POS_LAST) begin
                  pos_in            = POS_IDLE;
                  res_in.kind       = KIND_FRAME;
                  res_in.frame_good = frame_good;
                  if (frame_good) begin
                     if (pcnt_ff < COUNT_LIM) begin
                        psum_in = psum_ff + p_word;
                        pcnt_in = pcnt_ff + COUNT_W'(1);
                     end
                     if (tcnt_ff < COUNT_LIM) begin
                        tsum_in = tsum_ff + t_word;
                        tcnt_in = tcnt_ff + COUNT_W'(1);
                     end
                     age_in = '0;
                  end
               end
            end
            FUNC_TICK: begin
               if (age_ff != '1) begin
                  age_in = age_ff + AGE_W'(1);
               end
            end
            FUNC_FAIL: begin
               res_in.kind      = KIND_FAIL;
               res_in.reconnect = (age_ff > recon_ff);
            end
            FUNC_RD_PRES: begin
               res_in.kind  = KIND_PRES;
               res_in.fresh = fresh_now;
               res_in.value = plast_ff;
               sel_temp_in  = 1'b0;
            end
            FUNC_RD_TEMP: begin
               res_in.kind  = KIND_TEMP;
               res_in.fresh = fresh_now;
               res_in.value = tlast_ff;
               sel_temp_in  = 1'b1;
            end
            default: ;
         endcase
      end

      // Denominator product and numerator magnitude.
      if (cmd.load_div) begin
         den_in = DEN_W'(cnt_sel) * DEN_W'(div_sel);
         neg_in = sum_sel[SUM_W-1];
         num_in = NUM_W'(mag) << FRAC_BITS;
         rem_in = '0;
         quo_in = '0;
      end

      // One quotient bit per step.
      if (cmd.div_step) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         quo_in = {quo_ff[NUM_W-2:0], ge};
         num_in = {num_ff[NUM_W-2:0], 1'b0};
      end

      // Store the new average and clear the channel that it used.
      if (cmd.finish) begin
         res_in.value = sat;
         if (sel_temp_ff) begin
            tlast_in = sat;
            tsum_in  = '0;
            tcnt_in  = '0;
         end else begin
            plast_in = sat;
            psum_in  = '0;
            pcnt_in  = '0;
         end
      end

      if (cmd.load_out) begin
         rsp_in = res_ff;
      end
   end

   // State with a defined reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_FIRST;
         psum_ff  <= '0;
         tsum_ff  <= '0;
         pcnt_ff  <= '0;
         tcnt_ff  <= '0;
         plast_ff <= '0;
         tlast_ff <= '0;
         age_ff   <= '0;
         scale_ff <= SCALE_RESET;
         stale_ff <= STALE_RESET;
         recon_ff <= RECONNECT_RESET;
      end else begin
         pos_ff   <= pos_in;
         psum_ff  <= psum_in;
         tsum_ff  <= tsum_in;
         pcnt_ff  <= pcnt_in;
         tcnt_ff  <= tcnt_in;
         plast_ff <= plast_in;
         tlast_ff <= tlast_in;
         age_ff   <= age_in;
         scale_ff <= scale_in;
         stale_ff <= stale_in;
         recon_ff <= recon_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      crc_ff      <= crc_in;
      crc_ok_ff   <= crc_ok_in;
      sel_temp_ff <= sel_temp_in;
      neg_ff      <= neg_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[hw/rtl/diff_pressure_frame_check_average_unit.sv]
// ----------------------------------------------------------------------------
// Differential pressure frame checker and averager
// Checks six-byte sensor frames (two big-endian signed words, each followed
// by a CRC-8 with polynomial 0x31 and initial value 0xFF), sums the raw
// pressure and temperature of good frames, ages the sample on millisecond
// ticks, reports reconnect on transfer failure and returns signed
// Q(FRAC_BITS) averages on read. Requests are handled one at a time. A frame
// byte, a tick or an unused function code is taken in idle and gives no
// response; a frame completion, a failure report or a read that returns the
// kept average is staged in the result register and reaches the response
// register from the emit state once that register is free. A read that
// averages passes through the multiply step, the restoring divider, which
// retires one quotient bit per cycle over the 24 + FRAC_BITS numerator bits,
// and the saturate and output steps. A new request is taken as soon as the
// controller is idle again, even while the last response still waits on
// rsp_ready. There is no clearing pass after reset. Configuration writes are
// always accepted and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module diff_pressure_frame_check_average_unit import dpfca_pkg::*; #(
   parameter int MAX_COUNT = 255,
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int DIV_STEPS = SUM_W + FRAC_BITS;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            csr_write;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   dpfca_ctrl #(
      .DIV_STEPS (DIV_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dpfca_datapath #(
      .MAX_COUNT (MAX_COUNT),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/dpfca_checker.sv]
// ----------------------------------------------------------------------------
// Differential pressure frame checker port assertions
// Watches the response channel of the top level: field cleanliness per
// result kind and response hold under backpressure.
// ----------------------------------------------------------------------------
`include "diff_pressure_frame_check_average_unit_macros.svh"

module dpfca_checker import dpfca_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A frame status carries only the good flag.
   `DPFCA_ASSERT_NOW(a_frame_clean, rsp_valid && rsp_data.kind == KIND_FRAME, !rsp_data.fresh && rsp_data.value == 0 && !rsp_data.reconnect, "frame status carries stray fields")

   // A failure report carries only the reconnect flag.
   `DPFCA_ASSERT_NOW(a_fail_clean, rsp_valid && rsp_data.kind == KIND_FAIL, !rsp_data.frame_good && !rsp_data.fresh && rsp_data.value == 0, "failure report carries stray fields")

   // A read never reports frame status or reconnect.
   `DPFCA_ASSERT_NOW(a_read_clean, rsp_valid && (rsp_data.kind == KIND_PRES || rsp_data.kind == KIND_TEMP), !rsp_data.frame_good && !rsp_data.reconnect, "read result carries stray flags")

   // A stalled response holds until its transfer.
   `DPFCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

endmodule

bind diff_pressure_frame_check_average_unit dpfca_checker u_checker (.*);
